// File: rtl/core/image_upscale_2x_blend_assert.svh
// Assertion macros for the checker file of the 2x upscaler.
`ifndef IMAGE_UPSCALE_2X_BLEND_ASSERT_SVH
`define IMAGE_UPSCALE_2X_BLEND_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IU2B_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IU2B_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/iu2b_pkg.sv
// Types, constants and blend weights of the 2x upscaler.
`timescale 1ns / 1ps

package iu2b_pkg;

    localparam int COORD_W = 8;
    localparam int PIX_W   = 8;
    localparam int EXT_W   = 9;
    localparam int WGT_W   = 17;
    localparam int ACC_W   = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS = 1'b1;
    localparam logic [EXT_W-1:0]     EXT_RESET    = 9'd256;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Q16 blend weights; the copy weight is exactly one.
    localparam logic [WGT_W-1:0] W_BIG   = 17'd19825;
    localparam logic [WGT_W-1:0] W_MID   = 17'd16220;
    localparam logic [WGT_W-1:0] W_SMALL = 17'd13271;
    localparam logic [WGT_W-1:0] W_ONE   = 17'd65536;
    localparam logic [WGT_W-1:0] W_NONE  = 17'd0;

    // Neighbor order: bit 0 steps the column, bit 1 steps the row.
    localparam logic [1:0] NB_A1 = 2'd0;
    localparam logic [1:0] NB_B1 = 2'd1;
    localparam logic [1:0] NB_A2 = 2'd2;
    localparam logic [1:0] NB_B2 = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pixel_in;
    } t_in_word;

    typedef struct packed {
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic [PIX_W-1:0]   pixel_out;
        logic               border_hole;
    } t_out_word;

    typedef struct packed {
        logic       capture;
        logic       write;
        logic       rd_issue;
        logic [1:0] rd_idx;
        logic       load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_load;
        logic is_copy;
        logic is_hole;
        logic out_free;
    } t_dp_status;

    function automatic logic [WGT_W-1:0] blend_weight(
        input logic       copy,
        input logic       odd_col,
        input logic [1:0] nb
    );
        logic [WGT_W-1:0] w;
        w = W_NONE;
        if (copy) begin
            w = (nb == NB_A1) ? W_ONE : W_NONE;
        end else begin
            case (nb)
                NB_A1:   w = odd_col ? W_BIG : W_SMALL;
                NB_B1:   w = W_MID;
                NB_A2:   w = W_MID;
                NB_B2:   w = odd_col ? W_SMALL : W_BIG;
                default: w = W_NONE;
            endcase
        end
        return w;
    endfunction

endpackage

// File: rtl/core/iu2b_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module iu2b_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/iu2b_ctrl.sv
// Controller state machine: sequences load writes, neighbor reads and result handoff.
`timescale 1ns / 1ps

module iu2b_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  iu2b_pkg::t_dp_status i_status,
    output iu2b_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_WAIT,
        S_DONE
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_rd_idx;
    logic [1:0] n_rd_idx;
    logic [1:0] rd_last;

    // Copies need only the direct source pixel.
    assign rd_last = i_status.is_copy ? iu2b_pkg::NB_A1 : iu2b_pkg::NB_B2;

    always_comb begin
        n_state  = r_state;
        n_rd_idx = r_rd_idx;
        o_cmd    = '0;
        o_cmd.rd_idx = r_rd_idx;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_rd_idx = iu2b_pkg::NB_A1;
                if (i_status.is_load) begin
                    o_cmd.write = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_status.is_hole) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_rd_idx       = r_rd_idx + 2'd1;
                if (r_rd_idx == rd_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_idx <= iu2b_pkg::NB_A1;
        end else begin
            r_state  <= n_state;
            r_rd_idx <= n_rd_idx;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/core/iu2b_dp.sv
// Datapath: item capture, source store, weighted accumulate and output register.
`timescale 1ns / 1ps

module iu2b_dp #(
    parameter int SRC_DIM = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  iu2b_pkg::t_in_word             i_in,
    input  logic [iu2b_pkg::EXT_W-1:0]     i_out_rows,
    input  logic [iu2b_pkg::EXT_W-1:0]     i_out_cols,
    input  iu2b_pkg::t_dp_cmd              i_cmd,
    output iu2b_pkg::t_dp_status           o_status,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output iu2b_pkg::t_out_word            o_out
);

    localparam int DEPTH  = SRC_DIM * SRC_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    // Captured item.
    logic                          r_kind;
    logic [iu2b_pkg::COORD_W-1:0]  r_row;
    logic [iu2b_pkg::COORD_W-1:0]  r_col;
    logic [iu2b_pkg::PIX_W-1:0]    r_pix;

    logic                          interior;
    logic                          is_copy;
    logic                          is_hole;

    logic [iu2b_pkg::COORD_W:0]    src_r_sum;
    logic [iu2b_pkg::COORD_W:0]    src_c_sum;
    logic [iu2b_pkg::COORD_W-1:0]  src_r;
    logic [iu2b_pkg::COORD_W-1:0]  src_c;
    logic                          rd_ok;
    logic                          wr_ok;
    logic [ADDR_W-1:0]             rd_addr;
    logic [ADDR_W-1:0]             wr_addr;
    logic [ADDR_W-1:0]             ram_addr;
    logic                          ram_we;
    logic [iu2b_pkg::PIX_W-1:0]    ram_rdata;

    logic                          r_acc_en;
    logic [1:0]                    r_acc_idx;
    logic                          r_acc_zero;
    logic [iu2b_pkg::ACC_W-1:0]    r_acc;
    logic [iu2b_pkg::PIX_W-1:0]    sample;
    logic [iu2b_pkg::WGT_W-1:0]    weight;
    logic [iu2b_pkg::PIX_W+iu2b_pkg::WGT_W-1:0] product;

    logic                          r_out_valid;
    iu2b_pkg::t_out_word           r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_in.req_type;
            r_row  <= i_in.row;
            r_col  <= i_in.col;
            r_pix  <= i_in.pixel_in;
        end
    end

    assign interior = (r_row != '0) && (r_col != '0)
                   && (({1'b0, r_row} + 9'd1) < i_out_rows)
                   && (({1'b0, r_col} + 9'd1) < i_out_cols);
    assign is_copy = !r_row[0] && !r_col[0];
    assign is_hole = !is_copy && !interior;

    assign o_status.is_load  = (r_kind == iu2b_pkg::REQ_LOAD);
    assign o_status.is_copy  = is_copy;
    assign o_status.is_hole  = is_hole;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Neighbor coordinates: halve the output coordinate, rounding up on a step.
    assign src_r_sum = {1'b0, r_row} + {8'b0, i_cmd.rd_idx[1]};
    assign src_c_sum = {1'b0, r_col} + {8'b0, i_cmd.rd_idx[0]};
    assign src_r     = src_r_sum[iu2b_pkg::COORD_W:1];
    assign src_c     = src_c_sum[iu2b_pkg::COORD_W:1];

    assign rd_ok = ({24'b0, src_r} < 32'(SRC_DIM)) && ({24'b0, src_c} < 32'(SRC_DIM));
    assign wr_ok = ({24'b0, r_row} < 32'(SRC_DIM)) && ({24'b0, r_col} < 32'(SRC_DIM));

    assign rd_addr = ADDR_W'(32'(src_r) * 32'(SRC_DIM) + 32'(src_c));
    assign wr_addr = ADDR_W'(32'(r_row) * 32'(SRC_DIM) + 32'(r_col));

    assign ram_we   = i_cmd.write && wr_ok;
    assign ram_addr = i_cmd.write ? wr_addr : rd_addr;

    iu2b_ram #(
        .WIDTH (iu2b_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_pix),
        .o_rdata (ram_rdata)
    );

    // Out-of-range neighbors contribute zero.
    assign sample  = r_acc_zero ? '0 : ram_rdata;
    assign weight  = iu2b_pkg::blend_weight(is_copy, r_col[0], r_acc_idx);
    assign product = sample * weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.rd_issue;
        end
        r_acc_idx  <= i_cmd.rd_idx;
        r_acc_zero <= !rd_ok;
        if (i_cmd.capture) begin
            r_acc <= '0;
        end else if (r_acc_en) begin
            r_acc <= r_acc + product[iu2b_pkg::ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out.out_row     <= r_row;
            r_out.out_col     <= r_col;
            r_out.pixel_out   <= is_hole ? '0
                               : r_acc[iu2b_pkg::ACC_W-1:iu2b_pkg::ACC_W-iu2b_pkg::PIX_W];
            r_out.border_hole <= is_hole;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/core/image_upscale_2x_blend.sv
// Top level of the 2x upscaler: config registers, controller and datapath.
// The block takes one word at a time and accepts no new word until it is done with
//   the last: a load writes the store, a border hole reads no neighbor, a copy one
//   and a blend four, fetched one by one through the single store port; a result waits
//   while the previous one has not been taken from the output register.
// Reset: synchronous, active low; clears control state and sets out_rows and out_cols
//   to 256. The source store is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps

module image_upscale_2x_blend #(
    parameter int SRC_DIM = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  iu2b_pkg::t_in_word                i_in,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output iu2b_pkg::t_out_word               o_out,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [iu2b_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [iu2b_pkg::EXT_W-1:0]        i_cfg_wdata
);

    logic [iu2b_pkg::EXT_W-1:0] r_out_rows;
    logic [iu2b_pkg::EXT_W-1:0] r_out_cols;

    iu2b_pkg::t_dp_cmd    cmd;
    iu2b_pkg::t_dp_status status;

    // Output extents. The user must write them only while the block is idle, so the
    // datapath sees them stable for the whole of a query; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_rows <= iu2b_pkg::EXT_RESET;
            r_out_cols <= iu2b_pkg::EXT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                iu2b_pkg::CFG_OUT_ROWS: r_out_rows <= i_cfg_wdata;
                iu2b_pkg::CFG_OUT_COLS: r_out_cols <= i_cfg_wdata;
                default: begin
                    r_out_rows <= r_out_rows;
                end
            endcase
        end
    end

    // Controller: accept a word, decode it, then write the store, walk the
    // neighbor reads, or go straight to the result for a border hole.
    iu2b_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: holds the captured word, the source store, the Q16
    // accumulator and the output register that decouples the result side.
    iu2b_dp #(
        .SRC_DIM (SRC_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_rows  (r_out_rows),
        .i_out_cols  (r_out_cols),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// File: rtl/core/iu2b_checker.sv
// Port-level checker for the 2x upscaler and its bind to the top level.
`timescale 1ns / 1ps
`include "image_upscale_2x_blend_assert.svh"

module iu2b_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input iu2b_pkg::t_out_word o_out
);

    `IU2B_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result word dropped while stalled")
    `IU2B_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out), "result word changed while stalled")
    `IU2B_ASSERT_NOW(a_hole_zero, i_clk, i_rst_n, o_out_valid && o_out.border_hole, o_out.pixel_out == 8'd0, "border hole with nonzero pixel")
    `IU2B_ASSERT_NOW(a_copy_no_hole, i_clk, i_rst_n, o_out_valid && !o_out.out_row[0] && !o_out.out_col[0], !o_out.border_hole, "copy position flagged as hole")
    `IU2B_ASSERT_NOW(a_top_row_hole, i_clk, i_rst_n, o_out_valid && (o_out.out_row == 8'd0) && o_out.out_col[0], o_out.border_hole, "odd column on top row not a hole")

endmodule

bind image_upscale_2x_blend iu2b_checker u_iu2b_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// File: bench/tb_top.sv
// Self-checking bench for the 2x upscaler: loads, copies, blends and border holes.
`timescale 1ns / 1ps

module tb_top;
    import iu2b_pkg::*;

    localparam int SRC_DIM     = 128;
    localparam int HOLD_CYCLES = 300;   // one long output hold-off
    localparam int STALL_LIMIT = 4000;  // cycles with no word moving on either channel
    localparam int SETTLE      = 12;    // time for a word still in flight to finish, with margin
    localparam int MAX_SHOWN   = 40;

    // Receiver behavior, re-picked every so often.
    typedef enum int {RX_FREE, RX_COIN, RX_LIGHT, RX_COMB} t_rx_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_word             i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_word            o_out;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr  = CFG_OUT_ROWS;
    logic [EXT_W-1:0]     i_cfg_wdata = '0;

    // Shadow of the source store and of the extent registers.
    logic [PIX_W-1:0] src_pix     [SRC_DIM][SRC_DIM];
    bit               src_written [SRC_DIM][SRC_DIM];
    logic [EXT_W-1:0] ext_rows = EXT_RESET;
    logic [EXT_W-1:0] ext_cols = EXT_RESET;

    // Output pixels predicted for accepted queries, oldest first.
    t_out_word pixel_due[$];

    int  burst_left     = 0;
    bit  hold_req       = 1'b0;
    int  idle_cycles    = 0;
    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  results_seen   = 0;
    int  loads_done     = 0;
    int  loads_ignored  = 0;
    int  copies         = 0;
    int  blends         = 0;
    int  holes          = 0;
    int  settings_seen  = 0;

    image_upscale_2x_blend #(
        .SRC_DIM(SRC_DIM)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Source coordinates past the store read as zero.
    function automatic logic [PIX_W-1:0] src_at(input int unsigned r, input int unsigned c);
        if (r >= SRC_DIM || c >= SRC_DIM) begin
            return '0;
        end
        return src_pix[r][c];
    endfunction

    function automatic t_out_word upscale_pixel(input t_in_word w);
        t_out_word        res;
        int unsigned      r;
        int unsigned      c;
        int unsigned      acc;
        logic [PIX_W-1:0] a1;
        logic [PIX_W-1:0] a2;
        logic [PIX_W-1:0] b1;
        logic [PIX_W-1:0] b2;
        r = w.row;
        c = w.col;
        res.out_row     = w.row;
        res.out_col     = w.col;
        res.pixel_out   = '0;
        res.border_hole = 1'b0;
        if (r % 2 == 0 && c % 2 == 0) begin
            // Even row, even column: straight copy, never a hole.
            res.pixel_out = src_at(r / 2, c / 2);
        end else if (r == 0 || c == 0 || r + 1 >= ext_rows || c + 1 >= ext_cols) begin
            // Odd position on the border: no neighbors to blend, flag it.
            res.border_hole = 1'b1;
        end else begin
            a1 = src_at(r / 2, c / 2);
            a2 = src_at((r + 1) / 2, c / 2);
            b1 = src_at(r / 2, (c + 1) / 2);
            b2 = src_at((r + 1) / 2, (c + 1) / 2);
            // Odd column leans toward a1, even column on an odd row toward b2.
            if (c % 2 == 1) begin
                acc = a1 * W_BIG + b1 * W_MID + a2 * W_MID + b2 * W_SMALL;
            end else begin
                acc = a1 * W_SMALL + b1 * W_MID + a2 * W_MID + b2 * W_BIG;
            end
            // Weights sum to one in Q16, so truncation always fits 8 bits.
            res.pixel_out = PIX_W'(acc >> 16);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
            $display("MISMATCH at %0d ns: %s", $time, what);
        end
    endtask

    // Compare every accepted output word against the oldest prediction.
    always @(posedge i_clk) begin : check_out
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pixel_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word at row %0d col %0d",
                                          o_out.out_row, o_out.out_col));
            end else begin
                want = pixel_due.pop_front();
                if (o_out.out_row !== want.out_row) begin
                    report_mismatch($sformatf("out_row got %0d want %0d",
                                              o_out.out_row, want.out_row));
                end
                if (o_out.out_col !== want.out_col) begin
                    report_mismatch($sformatf("out_col got %0d want %0d",
                                              o_out.out_col, want.out_col));
                end
                if (o_out.pixel_out !== want.pixel_out) begin
                    report_mismatch($sformatf("pixel_out at (%0d,%0d) got %0d want %0d",
                                              want.out_row, want.out_col,
                                              o_out.pixel_out, want.pixel_out));
                end
                if (o_out.border_hole !== want.border_hole) begin
                    report_mismatch($sformatf("border_hole at (%0d,%0d) got %0b want %0b",
                                              want.out_row, want.out_col,
                                              o_out.border_hole, want.border_hole));
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: no word moved for %0d cycles, %0d results still due",
                     idle_cycles, pixel_due.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern of its own, plus one long hold-off on request
    // ------------------------------------------------------------------

    initial begin : out_stall
        t_rx_mode rx_mode;
        int       span;
        int       tick;
        rx_mode = RX_FREE;
        span    = 0;
        tick    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                // Hold ready low long enough for the block to back up into its input.
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (span == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    span    = $urandom_range(16, 160);
                end
                span--;
                tick++;
                case (rx_mode)
                    RX_FREE:  i_out_ready <= 1'b1;
                    RX_COIN:  i_out_ready <= 1'($urandom_range(0, 1));
                    RX_LIGHT: i_out_ready <= ($urandom_range(0, 3) != 0);
                    default:  i_out_ready <= (tick % 5 < 2);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one word; idle between bursts of random length; update the shadow on accept.
    task automatic send_word(input t_in_word w);
        int unsigned gap;
        t_out_word   want;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            // Now and then a long burst with no idling at all.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);

        if (w.req_type == REQ_LOAD) begin
            // Loads past the store are dropped by the block; drop them here too.
            if (w.row < SRC_DIM && w.col < SRC_DIM) begin
                src_pix[w.row][w.col]     = w.pixel_in;
                src_written[w.row][w.col] = 1'b1;
                loads_done++;
                items_sent++;
            end else begin
                loads_ignored++;
            end
        end else begin
            want = upscale_pixel(w);
            pixel_due.push_back(want);
            items_sent++;
            if (want.border_hole) begin
                holes++;
            end else if (!w.row[0] && !w.col[0]) begin
                copies++;
            end else begin
                blends++;
            end
        end
    endtask

    task automatic load_pixel(input int unsigned r, input int unsigned c, input int unsigned v);
        t_in_word w;
        w.req_type = REQ_LOAD;
        w.row      = COORD_W'(r);
        w.col      = COORD_W'(c);
        w.pixel_in = PIX_W'(v);
        send_word(w);
    endtask

    // The pixel field of a query is don't-care; keep it random so its bits toggle.
    task automatic query_pixel(input int unsigned r, input int unsigned c);
        t_in_word w;
        w.req_type = REQ_QUERY;
        w.row      = COORD_W'(r);
        w.col      = COORD_W'(c);
        w.pixel_in = PIX_W'($urandom_range(0, 255));
        send_word(w);
    endtask

    // Bias pixel values toward the extremes.
    function automatic int unsigned rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Pick a coordinate: mostly inside the extent, often on its edges, sometimes anywhere.
    function automatic int unsigned pick_coord(input int ext);
        int          v;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            v = (ext > 1) ? $urandom_range(0, (ext > 256) ? 255 : ext - 1) : $urandom_range(0, 3);
        end else if (sel < 8) begin
            case ($urandom_range(0, 5))
                0:       v = 0;
                1:       v = 1;
                2:       v = ext - 2;
                3:       v = ext - 1;
                4:       v = 254;
                default: v = 255;
            endcase
        end else begin
            v = $urandom_range(0, 255);
        end
        if (v < 0) begin
            v = 0;
        end
        if (v > 255) begin
            v = 255;
        end
        return v;
    endfunction

    // Load every in-store neighbor a query at (r, c) may read, so no query ever
    // touches an entry that was never written. Refresh some known ones too.
    task automatic fill_neighbors(input int unsigned r, input int unsigned c);
        int unsigned sr;
        int unsigned sc;
        for (int k = 0; k < 4; k++) begin
            sr = (r + (k >> 1)) >> 1;
            sc = (c + (k & 1)) >> 1;
            if (sr < SRC_DIM && sc < SRC_DIM &&
                (!src_written[sr][sc] || $urandom_range(0, 9) == 0)) begin
                load_pixel(sr, sc, rand_pixel());
            end
        end
    endtask

    // One random step: mostly well-formed load-then-query sequences, some noise.
    task automatic random_item();
        int unsigned pick;
        int unsigned r;
        int unsigned c;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            // Load outside the store: must be dropped without aliasing.
            r = $urandom_range(0, 255);
            c = $urandom_range(0, 255);
            if ($urandom_range(0, 1)) begin
                r = $urandom_range(SRC_DIM, 255);
            end else begin
                c = $urandom_range(SRC_DIM, 255);
            end
            load_pixel(r, c, rand_pixel());
        end else if (pick < 15) begin
            load_pixel($urandom_range(0, SRC_DIM - 1), $urandom_range(0, SRC_DIM - 1),
                       rand_pixel());
        end else begin
            r = pick_coord(ext_rows);
            c = pick_coord(ext_cols);
            fill_neighbors(r, c);
            query_pixel(r, c);
        end
    endtask

    task automatic run_random(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n) random_item();
    endtask

    // Drop valid, let every predicted result drain, then give the block time to finish
    // any load still in flight; only then is a register write safe.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pixel_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_extents(input int rows, input int cols);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_OUT_ROWS;
        i_cfg_wdata <= EXT_W'(rows);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_OUT_COLS;
        i_cfg_wdata <= EXT_W'(cols);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ext_rows = EXT_W'(rows);
        ext_cols = EXT_W'(cols);
        settings_seen++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Copies at both corners of the store, extreme pixel values, reset extents.
    task automatic test_copy_corners();
        load_pixel(0, 0, 255);
        load_pixel(SRC_DIM - 1, SRC_DIM - 1, 0);
        query_pixel(0, 0);
        query_pixel(254, 254);
    endtask

    // Both weight sets on distinct neighbors, then all-white to probe truncation.
    task automatic test_blend_weights();
        load_pixel(0, 1, 200);
        load_pixel(1, 0, 77);
        load_pixel(1, 1, 0);
        query_pixel(1, 1);
        query_pixel(1, 2);
        query_pixel(2, 1);
        load_pixel(0, 1, 255);
        load_pixel(1, 0, 255);
        load_pixel(1, 1, 255);
        query_pixel(1, 1);
    endtask

    // Odd positions on row 0, column 0, and the last row and column of the extent.
    task automatic test_border_holes();
        query_pixel(0, 1);
        query_pixel(1, 0);
        query_pixel(255, 3);
        query_pixel(3, 255);
    endtask

    // Loads past the store must not wrap onto low addresses.
    task automatic test_ignored_loads();
        load_pixel(SRC_DIM, 0, 99);
        load_pixel(0, SRC_DIM, 99);
        load_pixel(255, 255, 99);
        query_pixel(0, 0);
        query_pixel(254, 254);
    endtask

    // Hold the output off for a long stretch while queries keep coming.
    task automatic test_output_hold();
        hold_req = 1'b1;
        for (int n = 0; n < 40; n++) begin
            random_item();
        end
        wait_idle();
    endtask

    task automatic test_full_frame();
        set_extents(256, 256);
        run_random(500);
    endtask

    task automatic test_min_extent();
        set_extents(2, 2);
        run_random(150);
    endtask

    // Extents of 0 and 1 turn every odd position into a hole.
    task automatic test_degenerate_extent();
        set_extents(0, 1);
        run_random(60);
        set_extents(1, 0);
        run_random(60);
    endtask

    // Extents past 256 let row or column 255 blend against zeros beyond the store.
    task automatic test_oversized_extent();
        set_extents(511, 511);
        run_random(350);
    endtask

    task automatic test_random_extents();
        for (int n = 0; n < 2; n++) begin
            set_extents($urandom_range(2, 256), $urandom_range(2, 256));
            run_random(150);
        end
    endtask

    initial begin : main_seq
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_copy_corners();
        test_blend_weights();
        test_border_holes();
        test_ignored_loads();
        test_output_hold();
        test_full_frame();
        test_min_extent();
        test_degenerate_extent();
        test_oversized_extent();
        test_random_extents();

        // Drain and watch a little longer for stray words.
        wait_idle();
        repeat (SETTLE) @(posedge i_clk);

        $display("tb_top: %0d results checked: %0d copies, %0d blends, %0d border holes",
                 results_seen, copies, blends, holes);
        $display("tb_top: %0d loads, %0d dropped loads, %0d extent settings, %0d-cycle hold-off",
                 loads_done, loads_ignored, settings_seen, HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/iu2b_pkg.sv
rtl/core/iu2b_ram.sv
rtl/core/iu2b_ctrl.sv
rtl/core/iu2b_dp.sv
rtl/core/image_upscale_2x_blend.sv
rtl/core/iu2b_checker.sv
bench/tb_top.sv
